// File: design/vcd_pkg.sv
// shared types, format codes and constants for the vertex component decoder
// no dependencies
package vcd_pkg;

  typedef enum logic [2:0] {
    FMT_INT8    = 3'd0,
    FMT_UINT8   = 3'd1,
    FMT_INT16   = 3'd2,
    FMT_UINT16  = 3'd3,
    FMT_UINT32  = 3'd4,
    FMT_FLOAT32 = 3'd5
  } fmt_t;

  typedef enum logic [1:0] {
    CFG_FORMAT    = 2'd0,
    CFG_NORMALIZE = 2'd1,
    CFG_KIND      = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_INDEX = 2'd0,
    KIND_PAIR  = 2'd1,
    KIND_TRIPLE = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    REP_7  = 2'd0,
    REP_8  = 2'd1,
    REP_15 = 2'd2,
    REP_16 = 2'd3
  } rep_t;

  localparam logic [31:0] F_ONE_POS = 32'h3F80_0000;
  localparam logic [31:0] F_ONE_NEG = 32'hBF80_0000;
  localparam logic [31:0] F_ZERO    = 32'h0000_0000;

  // exponent bias plus scale of the integer path
  localparam logic [7:0] EXP_INT  = 8'd127;
  localparam logic [7:0] EXP_U32N = 8'd95;
  localparam logic [7:0] EXP_FRAC = 8'd63;

  typedef struct packed {
    logic [31:0] index_value;
    logic        bad_setting;
  } side_t;

  // m / (2^n - 1) for m below the divisor is 0.mmm... with period n
  function automatic logic [63:0] rep_fill(logic [15:0] m, rep_t sel);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < 64; i++) begin
      unique case (sel)
        REP_7:  r[63-i] = m[6 - (i % 7)];
        REP_8:  r[63-i] = m[7 - (i % 8)];
        REP_15: r[63-i] = m[14 - (i % 15)];
        REP_16: r[63-i] = m[15 - (i % 16)];
        default: r[63-i] = 1'b0;
      endcase
    end
    return r;
  endfunction

endpackage

// File: design/vcd_if.sv
// channel interfaces: element input, result output and register writes
// depends on nothing
interface vcd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] raw_first;
  logic [31:0] raw_second;
  logic [31:0] raw_third;
  modport source (output valid, raw_first, raw_second, raw_third, input ready);
  modport sink (input valid, raw_first, raw_second, raw_third, output ready);
endinterface

interface vcd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] float_first;
  logic [31:0] float_second;
  logic [31:0] float_third;
  logic [31:0] index_value;
  logic        bad_setting;
  modport source (output valid, float_first, float_second, float_third, index_value,
                  bad_setting, input ready);
  modport sink (input valid, float_first, float_second, float_third, index_value,
                bad_setting, output ready);
endinterface

interface vcd_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: design/vcd_lane.sv
// one component lane: decode, leading-one search, normalize shift, round
// depends on vcd_pkg
module vcd_lane (
  input  logic                clk,
  input  logic                en,
  input  logic                lane_used,
  input  vcd_pkg::fmt_t       fmt,
  input  logic                norm,
  input  logic [31:0]         raw,
  output logic [31:0]         word
);
  import vcd_pkg::*;

  logic [63:0] v_nxt, v1_r, v2_r;
  logic [7:0]  base_nxt, base1_r, base2_r;
  logic        stk_nxt, stk1_r, stk2_r, stk3_r;
  logic        sgn_nxt, sgn1_r, sgn2_r, sgn3_r;
  logic        frc_nxt, frc1_r, frc2_r, frc3_r;
  logic [31:0] fw_nxt, fw1_r, fw2_r, fw3_r;
  logic [5:0]  p_nxt, p2_r;
  logic [63:0] n3_r;
  logic [7:0]  e3_r;
  logic [7:0]  mag8;
  logic [15:0] mag16;
  logic [30:0] body;
  logic        g, st, rup;
  logic [31:0] word_r;

  // stage 1: decode into value, scale, sticky, sign and forced word
  always_comb begin
    mag8     = raw[7] ? (8'd0 - raw[7:0]) : raw[7:0];
    mag16    = raw[15] ? (16'd0 - raw[15:0]) : raw[15:0];
    v_nxt    = '0;
    base_nxt = EXP_INT;
    stk_nxt  = 1'b0;
    sgn_nxt  = 1'b0;
    frc_nxt  = 1'b0;
    fw_nxt   = F_ZERO;
    unique case (fmt)
      FMT_INT8: begin
        sgn_nxt = raw[7];
        if (!norm) begin
          v_nxt = {56'd0, mag8};
        end else if (mag8 >= 8'd127) begin
          frc_nxt = 1'b1;
          fw_nxt  = raw[7] ? F_ONE_NEG : F_ONE_POS;
        end else begin
          v_nxt    = rep_fill({8'd0, mag8}, REP_7);
          base_nxt = EXP_FRAC;
          stk_nxt  = 1'b1;
        end
      end
      FMT_UINT8: begin
        if (!norm) begin
          v_nxt = {56'd0, raw[7:0]};
        end else if (raw[7:0] == 8'hFF) begin
          frc_nxt = 1'b1;
          fw_nxt  = F_ONE_POS;
        end else begin
          v_nxt    = rep_fill({8'd0, raw[7:0]}, REP_8);
          base_nxt = EXP_FRAC;
          stk_nxt  = 1'b1;
        end
      end
      FMT_INT16: begin
        sgn_nxt = raw[15];
        if (!norm) begin
          v_nxt = {48'd0, mag16};
        end else if (mag16 >= 16'd32767) begin
          frc_nxt = 1'b1;
          fw_nxt  = raw[15] ? F_ONE_NEG : F_ONE_POS;
        end else begin
          v_nxt    = rep_fill(mag16, REP_15);
          base_nxt = EXP_FRAC;
          stk_nxt  = 1'b1;
        end
      end
      FMT_UINT16: begin
        if (!norm) begin
          v_nxt = {48'd0, raw[15:0]};
        end else if (raw[15:0] == 16'hFFFF) begin
          frc_nxt = 1'b1;
          fw_nxt  = F_ONE_POS;
        end else begin
          v_nxt    = rep_fill(raw[15:0], REP_16);
          base_nxt = EXP_FRAC;
          stk_nxt  = 1'b1;
        end
      end
      FMT_UINT32: begin
        v_nxt    = {32'd0, raw};
        base_nxt = norm ? EXP_U32N : EXP_INT;
      end
      FMT_FLOAT32: begin
        frc_nxt = 1'b1;
        fw_nxt  = raw;
      end
      default: begin
        frc_nxt = 1'b1;
        fw_nxt  = F_ZERO;
      end
    endcase
    if (!lane_used || (!frc_nxt && v_nxt == '0)) begin
      frc_nxt = 1'b1;
      fw_nxt  = F_ZERO;
    end
  end

  // stage 2: leading one position
  always_comb begin
    p_nxt = '0;
    for (int i = 0; i < 64; i++) begin
      if (v1_r[i]) p_nxt = 6'(i);
    end
  end

  // stage 4: round to nearest even
  always_comb begin
    g    = n3_r[39];
    st   = (|n3_r[38:0]) | stk3_r;
    rup  = g & (st | n3_r[40]);
    body = {e3_r, n3_r[62:40]} + {30'd0, rup};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v1_r    <= v_nxt;
      base1_r <= base_nxt;
      stk1_r  <= stk_nxt;
      sgn1_r  <= sgn_nxt;
      frc1_r  <= frc_nxt;
      fw1_r   <= fw_nxt;

      v2_r    <= v1_r;
      p2_r    <= p_nxt;
      base2_r <= base1_r;
      stk2_r  <= stk1_r;
      sgn2_r  <= sgn1_r;
      frc2_r  <= frc1_r;
      fw2_r   <= fw1_r;

      n3_r    <= v2_r << (6'd63 - p2_r);
      e3_r    <= base2_r + {2'd0, p2_r};
      stk3_r  <= stk2_r;
      sgn3_r  <= sgn2_r;
      frc3_r  <= frc2_r;
      fw3_r   <= fw2_r;

      word_r  <= frc3_r ? fw3_r : {sgn3_r, body};
    end
  end

  assign word = word_r;

endmodule

// File: design/vertex_component_decode.sv
// vertex component decoder top: config registers, valid pipeline, lanes
// depends on vcd_pkg, vcd_if and vcd_lane
// the valid registers v1_r to v4_r run in step with the lane stages
// throughput: one element per cycle unless the output stalls, with a four-stage lane pipeline
// the whole pipeline holds while the result register is full and not taken
// reset: synchronous active low, empties the pipeline and loads register defaults
module vertex_component_decode #(
  parameter int COMPONENT_LANES = 3
) (
  input logic      clk,
  input logic      rst_n,
  vcd_in_if.sink   in_if,
  vcd_out_if.source out_if,
  vcd_cfg_if.sink  cfg_if
);
  import vcd_pkg::*;

  localparam int LANES = (COMPONENT_LANES > 3) ? 3 : COMPONENT_LANES;

  fmt_t        fmt_r;
  logic        norm_r;
  logic [1:0]  kind_r;
  logic        v1_r, v2_r, v3_r, v4_r;
  logic        en;
  side_t       side_nxt, side1_r, side2_r, side3_r, side4_r;
  logic [31:0] raw [3];
  logic [31:0] res [3];
  logic [1:0]  used_cnt;

  assign en           = !v4_r || out_if.ready;
  assign in_if.ready  = en;
  assign cfg_if.ready = 1'b1;
  assign raw[0] = in_if.raw_first;
  assign raw[1] = in_if.raw_second;
  assign raw[2] = in_if.raw_third;
  assign used_cnt = (kind_r == KIND_INDEX) ? 2'd0 : (kind_r == KIND_PAIR) ? 2'd2 : 2'd3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r  <= FMT_FLOAT32;
      norm_r <= 1'b0;
      kind_r <= KIND_TRIPLE;
    end else if (cfg_if.valid) begin
      unique case (cfg_idx_t'(cfg_if.index))
        CFG_FORMAT:    fmt_r  <= fmt_t'(cfg_if.data[2:0]);
        CFG_NORMALIZE: norm_r <= cfg_if.data[0];
        CFG_KIND:      kind_r <= cfg_if.data[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    side_nxt = '0;
    if (kind_r == KIND_INDEX) begin
      unique case (fmt_r)
        FMT_UINT8:  side_nxt.index_value = {24'd0, in_if.raw_first[7:0]};
        FMT_UINT16: side_nxt.index_value = {16'd0, in_if.raw_first[15:0]};
        FMT_UINT32: side_nxt.index_value = in_if.raw_first;
        default:    side_nxt.bad_setting = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_if.valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1_r <= side_nxt;
      side2_r <= side1_r;
      side3_r <= side2_r;
      side4_r <= side3_r;
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_lane
    if (j < LANES) begin : g_on
      vcd_lane u_lane (
        .clk       (clk),
        .en        (en),
        .lane_used (2'(j) < used_cnt),
        .fmt       (fmt_r),
        .norm      (norm_r),
        .raw       (raw[j]),
        .word      (res[j])
      );
    end else begin : g_off
      assign res[j] = F_ZERO;
    end
  end

  assign out_if.valid        = v4_r;
  assign out_if.float_first  = res[0];
  assign out_if.float_second = res[1];
  assign out_if.float_third  = res[2];
  assign out_if.index_value  = side4_r.index_value;
  assign out_if.bad_setting  = side4_r.bad_setting;

  a_bad_no_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && out_if.bad_setting |-> out_if.index_value == 32'd0)
    else $error("flagged index carries a value");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready |=> v1_r)
    else $error("accepted request not in first stage");

  a_index_no_float: assert property (@(posedge clk) disable iff (!rst_n)
    out_if.valid && (out_if.bad_setting || out_if.index_value != 32'd0)
    |-> out_if.float_first == 32'd0)
    else $error("index result with float data");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && v4_r && !out_if.ready |=> v3_r && v4_r)
    else $error("stalled pipeline dropped a request");

endmodule

// File: tb/sv/tb_vertex_component_decode.sv
`timescale 1ns / 1ps
// testbench for vertex_component_decode: directed table then random phases,
// results checked against a bit-exact float conversion predictor
// depends on vcd_pkg, the vcd_if interfaces and the decoder rtl
module tb_vertex_component_decode;
  import vcd_pkg::*;

  localparam logic [2:0] FMT_SPARE6 = 3'd6;
  localparam logic [2:0] FMT_SPARE7 = 3'd7;
  localparam logic [1:0] KIND_WIDE = 2'd3;

  typedef struct {
    logic [31:0] f0;
    logic [31:0] f1;
    logic [31:0] f2;
    logic [31:0] idx;
    logic        bad;
  } decoded_t;

  typedef struct {
    logic [2:0]  fmt;
    logic        norm;
    logic [1:0]  kind;
    logic [31:0] r0;
    logic [31:0] r1;
    logic [31:0] r2;
    bit          typed;
    decoded_t    res;
  } vector_t;

  logic clk;
  logic rst_n;
  vcd_in_if in_bus();
  vcd_out_if out_bus();
  vcd_cfg_if cfg_bus();

  logic [2:0] cur_fmt;
  logic       cur_norm;
  logic [1:0] cur_kind;
  decoded_t   pending_q[$];
  vector_t    vectors[$];
  int         err_cnt;
  int         burst_left;
  int         stall_mode;

  vertex_component_decode #(.COMPONENT_LANES(3)) u_dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_bus), .out_if(out_bus), .cfg_if(cfg_bus)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  // correctly rounded mag / div as single, scaled down by 2^down
  function automatic logic [31:0] to_single(bit neg, logic [31:0] mag, logic [16:0] div,
                                            int down);
    logic [95:0] num;
    logic [95:0] q;
    logic [95:0] r;
    logic [95:0] rest;
    logic [95:0] half;
    logic [24:0] mant;
    int          p;
    bit          up;
    if (mag == 0) return F_ZERO;
    num = {4'd0, mag, 60'd0};
    q = num / div;
    r = num % div;
    p = 0;
    for (int i = 0; i < 96; i++) if (q[i]) p = i;
    mant = 25'(q >> (p - 23));
    rest = q & ((96'd1 << (p - 23)) - 1);
    half = 96'd1 << (p - 24);
    up = (rest > half) || (rest == half && (r != 0 || mant[0]));
    mant = mant + 25'(up);
    if (mant[24]) begin
      mant = mant >> 1;
      p++;
    end
    return {neg, 8'(p - 60 + 127 - down), mant[22:0]};
  endfunction

  function automatic logic [31:0] decode_lane(logic [31:0] raw);
    logic [16:0] u;
    case (cur_fmt)
      FMT_INT8: begin
        u = {9'd0, raw[7:0]};
        if (cur_norm && u == 17'h80) return F_ONE_NEG;
        if (u[7]) return to_single(1, 32'(17'h100 - u), cur_norm ? 17'd127 : 17'd1, 0);
        return to_single(0, 32'(u), cur_norm ? 17'd127 : 17'd1, 0);
      end
      FMT_UINT8: return to_single(0, {24'd0, raw[7:0]}, cur_norm ? 17'd255 : 17'd1, 0);
      FMT_INT16: begin
        u = {1'b0, raw[15:0]};
        if (cur_norm && u == 17'h8000) return F_ONE_NEG;
        if (u[15]) return to_single(1, 32'(17'h10000 - u), cur_norm ? 17'd32767 : 17'd1, 0);
        return to_single(0, 32'(u), cur_norm ? 17'd32767 : 17'd1, 0);
      end
      FMT_UINT16: return to_single(0, {16'd0, raw[15:0]}, cur_norm ? 17'd65535 : 17'd1, 0);
      FMT_UINT32: return to_single(0, raw, 17'd1, cur_norm ? 32 : 0);
      FMT_FLOAT32: return raw;
      default: return F_ZERO;
    endcase
  endfunction

  function automatic decoded_t decode_elem(logic [31:0] r0, logic [31:0] r1, logic [31:0] r2);
    decoded_t d;
    d = '{default: '0};
    if (cur_kind == KIND_INDEX) begin
      case (cur_fmt)
        FMT_UINT8: d.idx = {24'd0, r0[7:0]};
        FMT_UINT16: d.idx = {16'd0, r0[15:0]};
        FMT_UINT32: d.idx = r0;
        default: d.bad = 1'b1;
      endcase
    end else begin
      d.f0 = decode_lane(r0);
      d.f1 = decode_lane(r1);
      if (cur_kind != KIND_PAIR) d.f2 = decode_lane(r2);
    end
    return d;
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [31:0] data);
    @(negedge clk);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= idx;
    cfg_bus.data <= data;
    do @(posedge clk); while (!cfg_bus.ready);
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_bus.valid <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_mode(logic [2:0] fmt, logic norm, logic [1:0] kind);
    drain();
    write_reg(CFG_FORMAT, {$urandom} & ~32'h7 | {29'd0, fmt});
    write_reg(CFG_NORMALIZE, {$urandom} & ~32'h1 | {31'd0, norm});
    write_reg(CFG_KIND, {$urandom} & ~32'h3 | {30'd0, kind});
    cur_fmt = fmt;
    cur_norm = norm;
    cur_kind = kind;
  endtask

  task automatic send_elem(logic [31:0] r0, logic [31:0] r1, logic [31:0] r2,
                           bit typed, decoded_t res);
    if (burst_left == 0) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(0, 4)) @(negedge clk);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_bus.valid <= 1'b1;
    in_bus.raw_first <= r0;
    in_bus.raw_second <= r1;
    in_bus.raw_third <= r2;
    do @(posedge clk); while (!in_bus.ready);
    pending_q.push_back(typed ? res : decode_elem(r0, r1, r2));
  endtask

  function automatic logic [31:0] pick_raw();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return {($urandom_range(0, 255) == 0) ? 24'h0 : 24'($urandom), 8'h80};
      3: return {16'($urandom), 16'h8000};
      4: return {16'($urandom), 16'h7FFF};
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_vec(logic [2:0] fmt, logic norm, logic [1:0] kind,
                                  logic [31:0] r0, logic [31:0] r1, logic [31:0] r2,
                                  bit typed, logic [31:0] f0, logic [31:0] f1,
                                  logic [31:0] f2, logic [31:0] idx, logic bad);
    vector_t v;
    v = '{fmt, norm, kind, r0, r1, r2, typed, '{f0, f1, f2, idx, bad}};
    vectors.push_back(v);
  endfunction

  // result checker
  always @(posedge clk) begin
    decoded_t e;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_q.size() == 0) begin
        $error("unexpected result request");
        err_cnt++;
      end else begin
        e = pending_q.pop_front();
        if (out_bus.float_first !== e.f0) begin
          $error("float_first exp %h got %h", e.f0, out_bus.float_first);
          err_cnt++;
        end
        if (out_bus.float_second !== e.f1) begin
          $error("float_second exp %h got %h", e.f1, out_bus.float_second);
          err_cnt++;
        end
        if (out_bus.float_third !== e.f2) begin
          $error("float_third exp %h got %h", e.f2, out_bus.float_third);
          err_cnt++;
        end
        if (out_bus.index_value !== e.idx) begin
          $error("index_value exp %h got %h", e.idx, out_bus.index_value);
          err_cnt++;
        end
        if (out_bus.bad_setting !== e.bad) begin
          $error("bad_setting exp %b got %b", e.bad, out_bus.bad_setting);
          err_cnt++;
        end
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if ($urandom_range(0, 63) == 0) stall_mode = $urandom_range(0, 3);
    case (stall_mode)
      0: out_bus.ready <= 1'b1;
      1: out_bus.ready <= ($urandom_range(0, 1) != 0);
      2: out_bus.ready <= ($urandom_range(0, 7) != 0);
      default: out_bus.ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  initial begin
    vector_t v;
    int      n;
    err_cnt = 0;
    burst_left = 0;
    rst_n = 1'b0;
    in_bus.valid = 1'b0;
    in_bus.raw_first = '0;
    in_bus.raw_second = '0;
    in_bus.raw_third = '0;
    cfg_bus.valid = 1'b0;
    cfg_bus.index = CFG_FORMAT;
    cfg_bus.data = '0;
    cur_fmt = FMT_FLOAT32;
    cur_norm = 1'b0;
    cur_kind = KIND_TRIPLE;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset defaults pass float words through
    send_elem(32'hDEAD_BEEF, 32'h7F80_0000, 32'h8000_0000, 1,
              '{32'hDEAD_BEEF, 32'h7F80_0000, 32'h8000_0000, 32'h0, 1'b0});

    add_vec(FMT_INT8, 1, KIND_TRIPLE, 32'h80, 32'h7F, 32'h0, 1,
            F_ONE_NEG, F_ONE_POS, F_ZERO, 32'h0, 0);
    add_vec(FMT_INT8, 0, KIND_TRIPLE, 32'hFFFF_FF80, 32'h7F, 32'h1, 0, 0, 0, 0, 0, 0);
    add_vec(FMT_INT16, 1, KIND_TRIPLE, 32'h8000, 32'h7FFF, 32'h1, 1,
            F_ONE_NEG, F_ONE_POS, 32'h3800_0100, 32'h0, 0);
    add_vec(FMT_INT16, 0, KIND_PAIR, 32'h8000, 32'hFFFF, 32'h1234, 0, 0, 0, 0, 0, 0);
    add_vec(FMT_UINT8, 1, KIND_PAIR, 32'hFF, 32'h0, 32'hFFFF_FFFF, 1,
            F_ONE_POS, F_ZERO, F_ZERO, 32'h0, 0);
    add_vec(FMT_UINT8, 0, KIND_WIDE, 32'hFF, 32'h01, 32'h80, 0, 0, 0, 0, 0, 0);
    add_vec(FMT_UINT16, 1, KIND_WIDE, 32'hFFFF, 32'h1, 32'h8000, 0, 0, 0, 0, 0, 0);
    add_vec(FMT_UINT32, 1, KIND_TRIPLE, 32'hFFFF_FFFF, 32'h0, 32'h1, 1,
            F_ONE_POS, F_ZERO, 32'h2F80_0000, 32'h0, 0);
    add_vec(FMT_UINT32, 0, KIND_TRIPLE, 32'hFFFF_FFFF, 32'h0100_0001, 32'h0100_0003, 0,
            0, 0, 0, 0, 0);
    add_vec(FMT_UINT8, 0, KIND_INDEX, 32'h1234_5678, 32'hFFFF_FFFF, 32'h1, 1,
            F_ZERO, F_ZERO, F_ZERO, 32'h78, 0);
    add_vec(FMT_UINT8, 1, KIND_INDEX, 32'hFFFF_FFFF, 32'h1, 32'h1, 1,
            F_ZERO, F_ZERO, F_ZERO, 32'hFF, 0);
    add_vec(FMT_UINT16, 1, KIND_INDEX, 32'h1234_5678, 32'h1, 32'h1, 1,
            F_ZERO, F_ZERO, F_ZERO, 32'h5678, 0);
    add_vec(FMT_UINT32, 0, KIND_INDEX, 32'hFFFF_FFFF, 32'h1, 32'h1, 1,
            F_ZERO, F_ZERO, F_ZERO, 32'hFFFF_FFFF, 0);
    add_vec(FMT_INT8, 0, KIND_INDEX, 32'h5, 32'h1, 32'h1, 1, F_ZERO, F_ZERO, F_ZERO, 0, 1);
    add_vec(FMT_INT16, 1, KIND_INDEX, 32'h5, 32'h1, 32'h1, 1, F_ZERO, F_ZERO, F_ZERO, 0, 1);
    add_vec(FMT_FLOAT32, 0, KIND_INDEX, 32'h3F80_0000, 32'h1, 32'h1, 1,
            F_ZERO, F_ZERO, F_ZERO, 0, 1);
    add_vec(FMT_SPARE6, 0, KIND_INDEX, 32'h7, 32'h1, 32'h1, 1, F_ZERO, F_ZERO, F_ZERO, 0, 1);
    add_vec(FMT_SPARE7, 1, KIND_INDEX, 32'h7, 32'h1, 32'h1, 1, F_ZERO, F_ZERO, F_ZERO, 0, 1);
    add_vec(FMT_SPARE6, 0, KIND_TRIPLE, 32'h7, 32'h1, 32'h1, 1,
            F_ZERO, F_ZERO, F_ZERO, 32'h0, 0);
    add_vec(FMT_SPARE7, 1, KIND_PAIR, 32'h7, 32'h1, 32'h1, 1,
            F_ZERO, F_ZERO, F_ZERO, 32'h0, 0);

    foreach (vectors[i]) begin
      v = vectors[i];
      if (v.fmt != cur_fmt || v.norm != cur_norm || v.kind != cur_kind)
        set_mode(v.fmt, v.norm, v.kind);
      send_elem(v.r0, v.r1, v.r2, v.typed, v.res);
    end

    // random phases, each with its own register setting
    for (int ph = 0; ph < 26; ph++) begin
      if (ph < 8) set_mode(3'(ph % 6), ph[0], 2'(ph % 4));
      else set_mode(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                    2'($urandom_range(0, 3)));
      n = (ph == 0) ? 20 : $urandom_range(30, 70);
      for (int k = 0; k < n; k++)
        send_elem(pick_raw(), pick_raw(), pick_raw(), 0, '{default: '0});
    end

    drain();
    if (err_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: files.f
design/vcd_pkg.sv
design/vcd_if.sv
design/vcd_lane.sv
design/vertex_component_decode.sv
tb/sv/tb_vertex_component_decode.sv
